FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the filter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is held.
`define ADF_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ADF_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) \
    else $error(msg);

`endif

FILE: sv/adf_pkg.sv
// ----------------------------------------------------------------------------
// adf_pkg
// Types and constants of the ADC average / deadband filter.
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int CHANNELS    = 4;
  localparam int HIST_DEPTH  = 4;                 // power of two
  localparam int HIST_SHIFT  = $clog2(HIST_DEPTH);
  localparam int SUM_BITS    = SAMPLE_BITS + HIST_SHIFT;
  localparam int SCAN_BITS   = CHANNELS * SAMPLE_BITS;
  localparam int TDATA_BITS  = ((SCAN_BITS + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] scan_t;
  typedef sample_t [HIST_DEPTH-1:0] hist_t;

  localparam sample_t DEADBAND_RESET = sample_t'(5);

endpackage

FILE: sv/adf_tap_cell.sv
// ----------------------------------------------------------------------------
// adf_tap_cell
// One history tap: holds one scan and passes it on at each request.
// ----------------------------------------------------------------------------
module adf_tap_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  adf_pkg::scan_t d,
  output adf_pkg::scan_t q
);
  import adf_pkg::*;

  scan_t q_r;
  scan_t q_nxt;

  assign q_nxt = en ? d : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

FILE: sv/adf_hold_cell.sv
// ----------------------------------------------------------------------------
// adf_hold_cell
// Per-channel window average with deadband-held output register.
// ----------------------------------------------------------------------------
module adf_hold_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  adf_pkg::sample_t deadband,
  input  adf_pkg::hist_t   win,
  output adf_pkg::sample_t held
);
  import adf_pkg::*;

  logic [SUM_BITS-1:0] sum;
  sample_t             avg;
  sample_t             diff;
  sample_t             held_r;
  sample_t             held_nxt;

  always_comb begin
    sum = '0;
    for (int j = 0; j < HIST_DEPTH; j++) begin
      sum = sum + SUM_BITS'(win[j]);
    end
    avg  = sum[SUM_BITS-1:HIST_SHIFT];
    diff = (avg >= held_r) ? (avg - held_r) : (held_r - avg);
    held_nxt = held_r;
    // equal to the deadband keeps the old value
    if (en && (diff > deadband)) begin
      held_nxt = avg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign held = held_r;

endmodule

FILE: sv/adc_average_deadband_filter_top.sv
// ----------------------------------------------------------------------------
// adc_average_deadband_filter_top
// Four-channel moving average over the last four scans, with a deadband hold.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request is one scan of four 10-bit samples (ch0 in low bits).
//   out_* : one request per scan, the four held values after that scan.
//   cfg_* : deadband write (10 bits), always ready; write only while idle.
// Result: registered, valid in the cycle after the scan is taken.
// Throughput: one scan per cycle unless a result stalls; the window add and
//   deadband compare of each channel are combinational, and the held
//   registers double as the output register.
// Stall: while a result waits with out_tready low, in_tready drops; a
//   result taken in the same cycle lets the next scan in.
// Reset: history taps and held values clear to zero, deadband returns to 5,
//   no result pending.
// Structure: a chain of tap cells carries past scans; one hold cell per
//   channel sums its window, averages and applies the deadband.
// ----------------------------------------------------------------------------
module adc_average_deadband_filter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // scan in
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [adf_pkg::TDATA_BITS-1:0] in_tdata,   // sample_ch0..sample_ch3
  // result out
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [adf_pkg::TDATA_BITS-1:0] out_tdata,  // held_ch0..held_ch3
  // deadband register
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [adf_pkg::SAMPLE_BITS-1:0] cfg_data   // deadband
);
  import adf_pkg::*;

  logic    accept;
  logic    out_valid_r;
  logic    out_valid_nxt;
  sample_t deadband_r;
  sample_t deadband_nxt;
  scan_t   new_scan;
  scan_t   tap_q [HIST_DEPTH-1];
  hist_t   win [CHANNELS];
  sample_t held [CHANNELS];
  logic [SCAN_BITS-1:0] held_flat;

  // single output stage: take a new scan when it is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      new_scan[ch] = in_tdata[ch*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // tap chain: newest scan enters tap 0, older scans move one tap down
  for (genvar k = 0; k < HIST_DEPTH - 1; k++) begin : g_tap
    if (k == 0) begin : g_head
      adf_tap_cell u_tap (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .d     (new_scan),
        .q     (tap_q[k])
      );
    end else begin : g_body
      adf_tap_cell u_tap (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .d     (tap_q[k-1]),
        .q     (tap_q[k])
      );
    end
  end

  // window = incoming sample plus the three most recent stored ones
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      win[ch][0] = new_scan[ch];
      for (int j = 1; j < HIST_DEPTH; j++) begin
        win[ch][j] = tap_q[j-1][ch];
      end
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_hold
    adf_hold_cell u_hold (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (accept),
      .deadband (deadband_r),
      .win      (win[ch]),
      .held     (held[ch])
    );
  end

  always_comb begin
    deadband_nxt = (cfg_valid && cfg_ready) ? cfg_data : deadband_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      deadband_r  <= DEADBAND_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      deadband_r  <= deadband_nxt;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      held_flat[ch*SAMPLE_BITS +: SAMPLE_BITS] = held[ch];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_BITS'(held_flat);

endmodule

FILE: sv/adf_checker.sv
// ----------------------------------------------------------------------------
// adf_checker
// Port-level checks of the filter top, bound to every instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [adf_pkg::TDATA_BITS-1:0] out_tdata
);
  import adf_pkg::*;

  // every taken scan yields a result on the next cycle
  `ADF_ASSERT(a_scan_gives_result, clk, rst_n,
    (in_tvalid && in_tready) |=> out_tvalid, "scan taken without a result following")
  // a stalled result blocks new scans
  `ADF_ASSERT(a_stall_blocks_input, clk, rst_n,
    (out_tvalid && !out_tready) |-> !in_tready, "scan accepted over a stalled result")
  // a stalled result holds
  `ADF_ASSERT(a_stall_holds, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)),
    "stalled result changed")
  // reset empties the output stage
  `ADF_ASSERT_ALWAYS(a_reset_clears, clk,
    !rst_n |=> !out_tvalid, "result pending after reset")

endmodule

bind adc_average_deadband_filter_top adf_checker u_adf_checker (.*);
